// ===== hdl/scfb_pkg.sv =====
// Shared types, codes and frame constants of the speech command frame builder.
`default_nettype none
package scfb_pkg;

    // Input operation codes (carried in s_tuser)
    localparam logic [2:0] OP_TEXT_START = 3'd0;
    localparam logic [2:0] OP_TEXT_BYTE  = 3'd1;
    localparam logic [2:0] OP_STOP       = 3'd2;
    localparam logic [2:0] OP_PAUSE      = 3'd3;
    localparam logic [2:0] OP_RESUME     = 3'd4;
    localparam logic [2:0] OP_SET_BAUD   = 3'd5;

    // Frame bytes
    localparam logic [7:0] SYNC_BYTE      = 8'hFD;
    localparam logic [7:0] ZERO_BYTE      = 8'h00;
    localparam logic [7:0] TEXT_CMD       = 8'h01;
    localparam logic [7:0] LEN_OFFSET     = 8'd3;
    localparam logic [7:0] SHORT_LEN      = 8'h02;
    localparam logic [7:0] BAUD_LEN       = 8'h03;
    localparam logic [7:0] BAUD_CMD       = 8'h31;
    localparam logic [7:0] BAUD_CHK_SEED  = 8'hCF;
    localparam logic [7:0] STOP_CMD       = 8'h02;
    localparam logic [7:0] PAUSE_CMD      = 8'h03;
    localparam logic [7:0] RESUME_CMD     = 8'h04;
    localparam logic [7:0] STOP_CHK       = 8'hFD;
    localparam logic [7:0] PAUSE_CHK      = 8'hFC;
    localparam logic [7:0] RESUME_CHK     = 8'hFB;
    // XOR of the fixed text header bytes FD ^ 00 ^ 01 ^ 00
    localparam logic [7:0] HDR_XOR_SEED   = 8'hFC;

    localparam logic [7:0] MAX_LEN_RESET  = 8'd200;
    localparam int         QUEUE_DEPTH    = 4;

    // Byte position within a job (up to six bytes)
    localparam logic [2:0] POS_0 = 3'd0;
    localparam logic [2:0] POS_1 = 3'd1;
    localparam logic [2:0] POS_2 = 3'd2;
    localparam logic [2:0] POS_3 = 3'd3;
    localparam logic [2:0] POS_4 = 3'd4;
    localparam logic [2:0] POS_5 = 3'd5;

    typedef enum logic [2:0] {
        JOB_ERROR  = 3'd0,
        JOB_HEADER = 3'd1,
        JOB_TEXT   = 3'd2,
        JOB_STOP   = 3'd3,
        JOB_PAUSE  = 3'd4,
        JOB_RESUME = 3'd5,
        JOB_BAUD   = 3'd6
    } job_kind_t;

    // One classified transaction handed from the front to the back
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;      // length byte, text byte or baud select
        logic [7:0] chk;       // checksum appended when with_chk is set
        logic       with_chk;
    } job_t;

endpackage
`default_nettype wire

// ===== hdl/scfb_front.sv =====
// Front part: accepts input transactions, tracks the text frame and classifies them.
`default_nettype none
module scfb_front (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_wr_en,
    input  wire [7:0]          cfg_wr_data,
    input  wire                in_fire,
    input  wire [2:0]          op,
    input  wire [7:0]          text_length,
    input  wire [7:0]          text_byte,
    input  wire [1:0]          baud_select,
    output scfb_pkg::job_t     job
);

    logic [7:0] max_len_reg;
    logic       open_reg,  open_next;
    logic [7:0] left_reg,  left_next;
    logic [7:0] xor_reg,   xor_next;

    logic [7:0] byte_xor;
    logic [7:0] left_dec;
    logic [7:0] hdr_len;
    logic [7:0] hdr_xor;

    assign byte_xor = xor_reg ^ text_byte;
    assign left_dec = left_reg - 8'd1;
    assign hdr_len  = text_length + scfb_pkg::LEN_OFFSET;
    assign hdr_xor  = scfb_pkg::HDR_XOR_SEED ^ hdr_len;

    // Classify the transaction and work out the frame state after it
    always_comb begin
        job       = '{kind: scfb_pkg::JOB_ERROR, data: '0, chk: '0, with_chk: 1'b0};
        open_next = open_reg;
        left_next = left_reg;
        xor_next  = xor_reg;
        if (op == scfb_pkg::OP_TEXT_BYTE) begin
            if (open_reg) begin
                job.kind     = scfb_pkg::JOB_TEXT;
                job.data     = text_byte;
                job.chk      = byte_xor;
                job.with_chk = (left_dec == 8'd0);
                left_next    = left_dec;
                if (left_dec == 8'd0) begin
                    open_next = 1'b0;
                    xor_next  = '0;
                end else begin
                    xor_next  = byte_xor;
                end
            end
        end else if (!open_reg) begin
            unique case (op)
                scfb_pkg::OP_TEXT_START: begin
                    if (text_length <= max_len_reg) begin
                        job.kind     = scfb_pkg::JOB_HEADER;
                        job.data     = hdr_len;
                        job.chk      = hdr_xor;
                        job.with_chk = (text_length == 8'd0);
                        if (text_length != 8'd0) begin
                            open_next = 1'b1;
                            left_next = text_length;
                            xor_next  = hdr_xor;
                        end
                    end
                end
                scfb_pkg::OP_STOP:     job.kind = scfb_pkg::JOB_STOP;
                scfb_pkg::OP_PAUSE:    job.kind = scfb_pkg::JOB_PAUSE;
                scfb_pkg::OP_RESUME:   job.kind = scfb_pkg::JOB_RESUME;
                scfb_pkg::OP_SET_BAUD: begin
                    job.kind = scfb_pkg::JOB_BAUD;
                    job.data = {6'd0, baud_select};
                end
                default: job.kind = scfb_pkg::JOB_ERROR;
            endcase
        end
    end

    // Length limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= scfb_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Frame state, updated on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            left_reg <= '0;
            xor_reg  <= '0;
        end else if (in_fire) begin
            open_reg <= open_next;
            left_reg <= left_next;
            xor_reg  <= xor_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/scfb_queue.sv =====
// Short job queue between the front and back parts.
`default_nettype none
module scfb_queue #(
    parameter int Depth = scfb_pkg::QUEUE_DEPTH
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  wire scfb_pkg::job_t push_job,
    output logic               full,
    input  wire                pop,
    output scfb_pkg::job_t     head_job,
    output logic               empty
);

    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);

    scfb_pkg::job_t mem_reg [Depth];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full     = (count_reg == CW'(Depth));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/scfb_back.sv =====
// Back part: expands queued jobs into frame bytes, one per cycle while m_tready allows, into an output register.
`default_nettype none
module scfb_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire scfb_pkg::job_t head_job,
    input  wire                empty,
    output logic               pop,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    logic [2:0] pos_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       err_reg;

    logic       out_free;
    logic       emit;
    logic [2:0] last_pos;
    logic [7:0] byte_val;
    logic       frame_end;
    logic       is_err;

    assign out_free = !valid_reg || m_tready;
    assign emit     = !empty && out_free;
    assign pop      = emit && (pos_reg == last_pos);

    // Byte at the current position of the head job
    always_comb begin
        byte_val  = scfb_pkg::ZERO_BYTE;
        last_pos  = scfb_pkg::POS_4;
        frame_end = 1'b0;
        is_err    = 1'b0;
        unique case (head_job.kind)
            scfb_pkg::JOB_ERROR: begin
                last_pos = scfb_pkg::POS_0;
                is_err   = 1'b1;
            end
            scfb_pkg::JOB_TEXT: begin
                last_pos  = head_job.with_chk ? scfb_pkg::POS_1 : scfb_pkg::POS_0;
                byte_val  = (pos_reg == scfb_pkg::POS_0) ? head_job.data : head_job.chk;
                frame_end = (pos_reg == scfb_pkg::POS_1);
            end
            scfb_pkg::JOB_HEADER: begin
                last_pos  = head_job.with_chk ? scfb_pkg::POS_5 : scfb_pkg::POS_4;
                frame_end = (pos_reg == scfb_pkg::POS_5);
                case (pos_reg)
                    scfb_pkg::POS_0: byte_val = scfb_pkg::SYNC_BYTE;
                    scfb_pkg::POS_2: byte_val = head_job.data;
                    scfb_pkg::POS_3: byte_val = scfb_pkg::TEXT_CMD;
                    scfb_pkg::POS_5: byte_val = head_job.chk;
                    default:         byte_val = scfb_pkg::ZERO_BYTE;
                endcase
            end
            scfb_pkg::JOB_BAUD: begin
                last_pos  = scfb_pkg::POS_5;
                frame_end = (pos_reg == scfb_pkg::POS_5);
                case (pos_reg)
                    scfb_pkg::POS_0: byte_val = scfb_pkg::SYNC_BYTE;
                    scfb_pkg::POS_2: byte_val = scfb_pkg::BAUD_LEN;
                    scfb_pkg::POS_3: byte_val = scfb_pkg::BAUD_CMD;
                    scfb_pkg::POS_4: byte_val = head_job.data;
                    scfb_pkg::POS_5: byte_val = scfb_pkg::BAUD_CHK_SEED ^ head_job.data;
                    default:         byte_val = scfb_pkg::ZERO_BYTE;
                endcase
            end
            scfb_pkg::JOB_STOP, scfb_pkg::JOB_PAUSE, scfb_pkg::JOB_RESUME: begin
                frame_end = (pos_reg == scfb_pkg::POS_4);
                case (pos_reg)
                    scfb_pkg::POS_0: byte_val = scfb_pkg::SYNC_BYTE;
                    scfb_pkg::POS_2: byte_val = scfb_pkg::SHORT_LEN;
                    scfb_pkg::POS_3: begin
                        byte_val = (head_job.kind == scfb_pkg::JOB_STOP)  ? scfb_pkg::STOP_CMD :
                                   (head_job.kind == scfb_pkg::JOB_PAUSE) ? scfb_pkg::PAUSE_CMD :
                                                                            scfb_pkg::RESUME_CMD;
                    end
                    scfb_pkg::POS_4: begin
                        byte_val = (head_job.kind == scfb_pkg::JOB_STOP)  ? scfb_pkg::STOP_CHK :
                                   (head_job.kind == scfb_pkg::JOB_PAUSE) ? scfb_pkg::PAUSE_CHK :
                                                                            scfb_pkg::RESUME_CHK;
                    end
                    default:         byte_val = scfb_pkg::ZERO_BYTE;
                endcase
            end
            default: begin
                last_pos = scfb_pkg::POS_0;
                is_err   = 1'b1;
            end
        endcase
    end

    // Byte position within the head job
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (emit) begin
            pos_reg <= (pos_reg == last_pos) ? '0 : pos_reg + 3'd1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            data_reg <= byte_val;
            last_reg <= frame_end;
            err_reg  <= is_err;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule
`default_nettype wire

// ===== hdl/speech_command_frame_builder.sv =====
// Top level of the speech command frame builder: front, job queue and byte back end.
//
// Usage:
//   Input stream s_*: one command transaction per handshake; s_tuser carries the
//   operation, s_tdata the text length, text byte and baud select.
//   Output stream m_*: one frame byte per transaction; m_tlast marks the final
//   byte of a frame, m_tuser marks an error result (data 0, tlast 0).
//   cfg_wr_en / cfg_wr_data write the text length limit (reset value 200);
//   write it only while the block is idle.
// Timing:
//   The front takes one transaction per cycle while the job queue has room.
//   The back end sends one byte per cycle while m_tready allows, so a command
//   yields as many output bytes as its frame has: 1 for a text byte or an error,
//   2 for the last text byte, 5 for a header or short command, 6 for a baud
//   command or an empty text. The first byte of a transaction goes through the
//   job queue storage and then the output register before it is on m_tdata.
// Reset (aresetn low, synchronous): queue emptied, no text frame open, output
//   register empty, limit back to 200.
// Stall: while m_tready is low the output byte holds; the queue absorbs up to
//   QueueDepth further transactions, after which s_tready drops.
`default_nettype none
module speech_command_frame_builder #(
    parameter int QueueDepth = scfb_pkg::QUEUE_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration
    input  wire         cfg_wr_en,
    input  wire  [7:0]  cfg_wr_data,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [7:0] text_length, [15:8] text_byte, [17:16] baud_select
    input  wire  [2:0]  s_tuser,   // [2:0] op
    // Output stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast,
    output logic        m_tuser    // [0] error
);

    scfb_pkg::job_t front_job;
    scfb_pkg::job_t head_job;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           in_fire;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    scfb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .op          (s_tuser),
        .text_length (s_tdata[7:0]),
        .text_byte   (s_tdata[15:8]),
        .baud_select (s_tdata[17:16]),
        .job         (front_job)
    );

    scfb_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (in_fire),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    scfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
